[design/hist_stats_pkg.sv]
// package for the histogram with running statistics
// types, opcodes, state codes and sizes used by the top level
// no dependencies
package hist_stats_pkg;

   localparam int NUM_BUCKETS = 1024;
   localparam int BUCKET_AW   = $clog2(NUM_BUCKETS);
   localparam int STAT_W      = 64;
   localparam int IDX_W       = 16;
   localparam int CFG_W       = 11;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CFG_W-1:0]  BUCKETS_RESET = CFG_W'(1024);
   localparam logic [STAT_W-1:0] MIN_RESET     = {STAT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      REG_BUCKETS_IN_USE = 1'b0,
      REG_UNUSED         = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [63:0]      sample_value;
      logic [IDX_W-1:0] bucket_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] sample_count;
      logic [STAT_W-1:0] raw_total;
      logic [STAT_W-1:0] smallest_sample;
      logic [STAT_W-1:0] largest_sample;
      logic [STAT_W-1:0] overflow_count;
      logic [STAT_W-1:0] bucket_count;
   } rsp_type;

endpackage

[design/hist_stats_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module hist_stats_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/histogram_with_stats_unit.sv]
// histogram engine: bucket counts in a ram, count, sum, min, max, overflow in registers
// one command at a time, none taken while busy: ram read on the accept edge, modify and write back in the exec state
// result strobe in the cycle after the write-back cycle
// after reset and after each clear the ram is zeroed, one entry a cycle, busy until all 1024 are zeroed
// reset is synchronous, active high; the receiver cannot stall results
// depends on hist_stats_pkg and hist_stats_ram
module histogram_with_stats_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hist_stats_pkg::req_type             req_data,
   output logic                                rsp_strobe,
   output hist_stats_pkg::rsp_type             rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hist_stats_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hist_stats_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hist_stats_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import hist_stats_pkg::*;

   state_type              state_ff, state_in;
   logic [BUCKET_AW-1:0]   sweep_ff, sweep_in;
   req_type                req_ff;
   logic [CFG_W-1:0]       buckets_ff;
   logic [STAT_W-1:0]      count_ff, sum_ff, min_ff, max_ff, ovf_ff;
   logic [STAT_W-1:0]      count_in, sum_in, min_in, max_in, ovf_in;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   exec_done;
   logic                   sweep_last;
   logic                   in_range;
   logic [IDX_W:0]         limit;
   logic [STAT_W-1:0]      bucket_val;
   logic                   ram_wr_en;
   logic [BUCKET_AW-1:0]   ram_wr_addr;
   logic [STAT_W-1:0]      ram_wr_data;
   logic [STAT_W-1:0]      ram_rd_data;
   reg_index_type          csr_index;
   logic                   csr_write;

   hist_stats_ram #(
      .WIDTH (STAT_W),
      .DEPTH (NUM_BUCKETS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (req_data.bucket_index[BUCKET_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // configuration port
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_BUCKETS_IN_USE: csr_prdata = CSR_DW'(buckets_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buckets_ff <= BUCKETS_RESET;
      end else if (csr_write && csr_index == REG_BUCKETS_IN_USE) begin
         buckets_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // sequencer
   assign accept     = start && !busy;
   assign exec_done  = state_ff == ST_EXEC;
   assign sweep_last = sweep_ff == BUCKET_AW'(NUM_BUCKETS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (req_ff.opcode == OP_CLEAR) state_in = ST_SWEEP;
            else                           state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign limit = (IDX_W+1)'(buckets_ff) > (IDX_W+1)'(NUM_BUCKETS)
                ? (IDX_W+1)'(NUM_BUCKETS) : (IDX_W+1)'(buckets_ff);
   assign in_range = {1'b0, req_ff.bucket_index} < limit;

   always_comb begin
      busy        = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_ff.bucket_index[BUCKET_AW-1:0];
      ram_wr_data = ram_rd_data + STAT_W'(1);
      sweep_in    = sweep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_EXEC: begin
            ram_wr_en = req_ff.opcode == OP_ADD && in_range;
            sweep_in  = '0;
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + BUCKET_AW'(1);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // statistics update
   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      ovf_in     = ovf_ff;
      bucket_val = '0;
      case (req_ff.opcode)
         OP_ADD: begin
            count_in = count_ff + STAT_W'(1);
            sum_in   = sum_ff + req_ff.sample_value;
            if (req_ff.sample_value < min_ff) min_in = req_ff.sample_value;
            if (req_ff.sample_value > max_ff) max_in = req_ff.sample_value;
            if (in_range) bucket_val = ram_rd_data + STAT_W'(1);
            else          ovf_in     = ovf_ff + STAT_W'(1);
         end
         OP_READ: begin
            if (in_range) bucket_val = ram_rd_data;
         end
         OP_CLEAR: begin
            count_in = '0;
            sum_in   = '0;
            min_in   = MIN_RESET;
            max_in   = '0;
            ovf_in   = '0;
         end
         default: begin
            bucket_val = '0;
         end
      endcase
      rsp_in.sample_count    = count_in;
      rsp_in.raw_total       = sum_in;
      rsp_in.smallest_sample = min_in;
      rsp_in.largest_sample  = max_in;
      rsp_in.overflow_count  = ovf_in;
      rsp_in.bucket_count    = bucket_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         min_ff        <= MIN_RESET;
         max_ff        <= '0;
         ovf_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         rsp_strobe_ff <= exec_done;
         if (exec_done) begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec_done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
